>>> rtl/stip_pkg.sv
// Shared types and constants for the string-to-integer parser.
package stip_pkg;

	localparam int MAX_STRING_LEN = 4095;
	localparam int COUNT_W        = 12;
	localparam int BASE_W         = 6;
	localparam int DIGIT_W        = 6;
	localparam int VALUE_W        = 64;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	typedef struct packed {
		logic               start;
		logic               is_blank;
		logic               is_sign;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic               is_digit;
		logic [DIGIT_W-1:0] digit;
	} item_t;

endpackage

>>> rtl/string_to_integer_parser_unit.sv
// Top level of the string-to-integer parser.
// Takes one character per transfer and returns one result per character: the signed value so
// far, a stopped flag and the consumed offset. Sustains one character per clock while the
// result output is not stalled; a character loads the classifier register, then passes
// through the four-entry queue into the result register, with the parse engine doing one
// multiply-add by the radix per cycle while it is taking characters. The base register is
// sampled when a string reaches its first non-blank character; write it only while the block
// is idle.
module string_to_integer_parser_unit import stip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BASE_W-1:0] cfg_wdata,      // number_base
	input  logic [7:0]        s_axis_tdata,   // [7:0] char_code
	input  logic              s_axis_tuser,   // [0] string_start
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	output logic [79:0]       m_axis_tdata,   // [63:0] parsed_value, [64] parse_stopped,
	                                          // [76:65] end_offset
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready
);

	logic [BASE_W-1:0] number_base_q;
	item_t             item_s1;
	logic              valid_s1;
	logic              push_ready;
	logic              pop_valid;
	item_t             pop_item;
	logic              pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_RESET;
		end else if (cfg_we) begin
			number_base_q <= cfg_wdata;
		end
	end

	stip_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.item_s1       (item_s1),
		.valid_s1      (valid_s1),
		.push_ready    (push_ready)
	);

	stip_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (valid_s1),
		.push_item  (item_s1),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	stip_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.number_base   (number_base_q),
		.pop_valid     (pop_valid),
		.pop_item      (pop_item),
		.pop_ready     (pop_ready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

endmodule

>>> rtl/stip_front.sv
// Front end: accepts characters, classifies them and stages them for the queue.
module stip_front import stip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] s_axis_tdata,
	input  logic       s_axis_tuser,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	output item_t      item_s1,
	output logic       valid_s1,
	input  logic       push_ready
);

	item_t cls;
	logic  [7:0] diff;

	always_comb begin
		cls          = '0;
		diff         = 8'd0;
		cls.start    = s_axis_tuser;
		cls.is_blank = (s_axis_tdata == CH_SPACE) || (s_axis_tdata == CH_TAB);
		cls.is_sign  = (s_axis_tdata == CH_PLUS) || (s_axis_tdata == CH_MINUS);
		cls.is_minus = (s_axis_tdata == CH_MINUS);
		cls.is_zero  = (s_axis_tdata == CH_ZERO);
		cls.is_x     = (s_axis_tdata == CH_LX) || (s_axis_tdata == CH_UX);
		if (s_axis_tdata >= CH_ZERO && s_axis_tdata <= CH_NINE) begin
			diff         = s_axis_tdata - CH_ZERO;
			cls.is_digit = 1'b1;
		end else if (s_axis_tdata >= CH_LA && s_axis_tdata <= CH_LZ) begin
			diff         = s_axis_tdata - CH_LA + 8'd10;
			cls.is_digit = 1'b1;
		end else if (s_axis_tdata >= CH_UA && s_axis_tdata <= CH_UZ) begin
			diff         = s_axis_tdata - CH_UA + 8'd10;
			cls.is_digit = 1'b1;
		end
		cls.digit = diff[DIGIT_W-1:0];
	end

	assign s_axis_tready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= cls;
		end
	end

endmodule

>>> rtl/stip_queue.sv
// Short FIFO between the classifier and the parse engine.
module stip_queue import stip_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  push_ready,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop_ready
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q < QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/stip_back.sv
// Parse engine: runs the prefix and digit state machine and holds the result register.
module stip_back import stip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BASE_W-1:0] number_base,
	input  logic              pop_valid,
	input  item_t             pop_item,
	output logic              pop_ready,
	output logic [79:0]       m_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready
);

	typedef enum logic [2:0] {
		PH_BLANK,
		PH_PREFIX,
		PH_ZERO,
		PH_DIGITS,
		PH_STOP
	} phase_t;

	phase_t               phase_q;
	logic                 neg_q;
	logic [BASE_W-1:0]    base_q;
	logic [VALUE_W-1:0]   value_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [79:0]          data_q;
	logic                 valid_q;

	phase_t               phase_e;
	logic                 neg_e;
	logic [VALUE_W-1:0]   value_e;
	logic [COUNT_W-1:0]   cnt_e;

	phase_t               phase_n;
	logic                 neg_n;
	logic [BASE_W-1:0]    base_n;
	logic [VALUE_W-1:0]   value_n;
	logic [COUNT_W-1:0]   cnt_n;

	logic                 pop;
	logic                 can_take;

	assign pop_ready     = !valid_q || m_axis_tready;
	assign pop           = pop_valid && pop_ready;
	assign m_axis_tdata  = data_q;
	assign m_axis_tvalid = valid_q;

	assign phase_e  = pop_item.start ? PH_BLANK : phase_q;
	assign neg_e    = pop_item.start ? 1'b0 : neg_q;
	assign value_e  = pop_item.start ? '0 : value_q;
	assign cnt_e    = pop_item.start ? '0 : cnt_q;
	assign can_take = (cnt_e < COUNT_W'(MAX_STRING_LEN));

	always_comb begin
		logic              pfx;
		logic [BASE_W-1:0] pb;
		logic              do_digit;
		logic [BASE_W-1:0] dbase;
		logic              do_take;
		phase_t            tgt;
		logic              set_neg;
		logic              upd;
		logic [VALUE_W-1:0] dterm;

		pfx      = 1'b0;
		pb       = base_q;
		do_digit = 1'b0;
		dbase    = base_q;
		do_take  = 1'b0;
		tgt      = phase_e;
		set_neg  = 1'b0;
		upd      = 1'b0;
		phase_n  = phase_e;
		neg_n    = neg_e;
		base_n   = base_q;
		value_n  = value_e;
		cnt_n    = cnt_e;
		dterm    = neg_e ? (VALUE_W'(0) - VALUE_W'(pop_item.digit)) : VALUE_W'(pop_item.digit);

		unique case (phase_e)
			PH_BLANK: begin
				base_n = number_base;
				if (pop_item.is_blank) begin
					do_take = 1'b1;
					tgt     = PH_BLANK;
				end else if (pop_item.is_sign) begin
					do_take = 1'b1;
					tgt     = PH_PREFIX;
					set_neg = 1'b1;
				end else begin
					pfx = 1'b1;
					pb  = number_base;
				end
			end
			PH_PREFIX: begin
				pfx = 1'b1;
				pb  = base_q;
			end
			PH_ZERO: begin
				if (pop_item.is_x) begin
					base_n  = BASE_HEX;
					do_take = 1'b1;
					tgt     = PH_DIGITS;
				end else begin
					do_digit = 1'b1;
					dbase    = base_q;
				end
			end
			PH_DIGITS: begin
				do_digit = 1'b1;
				dbase    = base_q;
			end
			default: begin
				phase_n = PH_STOP;
			end
		endcase

		if (pfx) begin
			if (pb == BASE_AUTO) begin
				if (pop_item.is_zero) begin
					base_n  = BASE_OCT;
					do_take = 1'b1;
					tgt     = PH_ZERO;
				end else begin
					base_n   = BASE_DEC;
					do_digit = 1'b1;
					dbase    = BASE_DEC;
				end
			end else if (pb == BASE_HEX && pop_item.is_zero) begin
				do_take = 1'b1;
				tgt     = PH_ZERO;
			end else begin
				do_digit = 1'b1;
				dbase    = pb;
			end
		end

		if (do_digit) begin
			if (pop_item.is_digit && (pop_item.digit < dbase)) begin
				do_take = 1'b1;
				tgt     = PH_DIGITS;
				upd     = 1'b1;
			end else begin
				phase_n = PH_STOP;
			end
		end

		if (do_take) begin
			if (can_take) begin
				cnt_n   = cnt_e + 1'b1;
				phase_n = tgt;
				if (set_neg) begin
					neg_n = pop_item.is_minus;
				end
				if (upd) begin
					value_n = value_e * VALUE_W'(dbase) + dterm;
				end
			end else begin
				phase_n = PH_STOP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
			neg_q   <= 1'b0;
			base_q  <= '0;
			value_q <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
			data_q  <= '0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				base_q  <= base_n;
				value_q <= value_n;
				cnt_q   <= cnt_n;
				data_q  <= {3'b000, cnt_n, (phase_n == PH_STOP), value_n};
				valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !pop_item.start && phase_q == PH_STOP) |=> (phase_q == PH_STOP))
		else $error("parse left the stopped phase without a string start");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_W'(MAX_STRING_LEN))
		else $error("consumed count beyond string length bound");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !pop_item.start) |=>
		(cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1))
		else $error("consumed count moved by more than one character");

	a_result_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (data_q[76:65] == cnt_q && data_q[63:0] == value_q))
		else $error("result register out of step with parse state");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the string-to-integer parser unit.
`timescale 1ns / 100ps

module tb_top;
	import stip_pkg::*;

	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [6:0] NO_DIGIT = 7'd127;
	localparam logic [BASE_W-1:0] PHASE_BASES [9] = '{
		BASE_AUTO, BASE_DEC, BASE_HEX, BASE_OCT, 6'd2, 6'd36, 6'd1, 6'd37, 6'd63
	};

	typedef enum logic [2:0] {
		SCAN_BLANK, SCAN_PREFIX, SCAN_ZERO, SCAN_DIGITS, SCAN_DONE
	} scan_e;

	typedef enum logic {ROW_CHAR, ROW_BASE} row_kind_e;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               stopped;
		logic [COUNT_W-1:0] offset;
	} parse_result_t;

	typedef struct packed {
		row_kind_e     kind;
		logic [7:0]    code;
		logic          opens;
		logic          fixed;
		parse_result_t res;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [BASE_W-1:0] cfg_wdata;
	logic [7:0]        s_axis_tdata;
	logic              s_axis_tuser;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [79:0]       m_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;

	scan_e              scan_phase = SCAN_BLANK;
	logic               neg_sign   = 1'b0;
	logic [BASE_W-1:0]  run_base   = BASE_AUTO;
	logic [BASE_W-1:0]  base_reg   = BASE_RESET;
	logic [VALUE_W-1:0] acc_value  = '0;
	logic [COUNT_W-1:0] used_count = '0;

	parse_result_t expected_results [$];
	int            error_count = 0;
	int            char_count  = 0;
	int            cycle_count = 0;
	bit            quiet       = 1'b0;

	stim_row_t stim_table [$] = '{
		'{ROW_CHAR, CH_SPACE, 1'b0, 1'b1, '{64'd0, 1'b0, 12'd1}},
		'{ROW_CHAR, CH_TAB,   1'b0, 1'b1, '{64'd0, 1'b0, 12'd2}},
		'{ROW_CHAR, CH_MINUS, 1'b0, 1'b1, '{64'd0, 1'b0, 12'd3}},
		'{ROW_CHAR, CH_NINE,  1'b0, 1'b1, '{-64'sd9, 1'b0, 12'd4}},
		'{ROW_CHAR, CH_UZ,    1'b0, 1'b1, '{-64'sd9, 1'b1, 12'd4}},
		'{ROW_CHAR, CH_LX,    1'b0, 1'b1, '{-64'sd9, 1'b1, 12'd4}},
		'{ROW_CHAR, CH_PLUS,  1'b1, 1'b1, '{64'd0, 1'b0, 12'd1}},
		'{ROW_CHAR, CH_NUL,   1'b0, 1'b1, '{64'd0, 1'b1, 12'd1}},
		'{ROW_CHAR, 8'hFF,    1'b1, 1'b1, '{64'd0, 1'b1, 12'd0}},
		'{ROW_BASE, 8'(BASE_AUTO), 1'b0, 1'b0, '0},
		'{ROW_CHAR, CH_ZERO,  1'b1, 1'b0, '0},
		'{ROW_CHAR, CH_LX,    1'b0, 1'b0, '0},
		'{ROW_CHAR, "f",      1'b0, 1'b0, '0},
		'{ROW_CHAR, "G",      1'b0, 1'b0, '0},
		'{ROW_CHAR, CH_ZERO,  1'b1, 1'b0, '0},
		'{ROW_CHAR, "7",      1'b0, 1'b0, '0},
		'{ROW_CHAR, "8",      1'b0, 1'b0, '0},
		'{ROW_CHAR, "5",      1'b1, 1'b0, '0},
		'{ROW_BASE, 8'(BASE_HEX), 1'b0, 1'b0, '0},
		'{ROW_CHAR, CH_ZERO,  1'b1, 1'b0, '0},
		'{ROW_CHAR, CH_NINE,  1'b0, 1'b0, '0},
		'{ROW_CHAR, CH_ZERO,  1'b1, 1'b1, '{64'd0, 1'b0, 12'd1}},
		'{ROW_CHAR, CH_UX,    1'b0, 1'b1, '{64'd0, 1'b0, 12'd2}},
		'{ROW_CHAR, "g",      1'b0, 1'b1, '{64'd0, 1'b1, 12'd2}},
		'{ROW_BASE, 8'd1,     1'b0, 1'b0, '0},
		'{ROW_CHAR, CH_ZERO,  1'b1, 1'b0, '0},
		'{ROW_CHAR, "1",      1'b0, 1'b0, '0},
		'{ROW_BASE, 8'd63,    1'b0, 1'b0, '0},
		'{ROW_CHAR, CH_LZ,    1'b1, 1'b0, '0},
		'{ROW_BASE, 8'd2,     1'b0, 1'b0, '0},
		'{ROW_CHAR, CH_UZ,    1'b0, 1'b0, '0},
		'{ROW_CHAR, CH_NUL,   1'b0, 1'b0, '0}
	};

	string_to_integer_parser_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [6:0] digit_value(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
		if (c >= CH_LA && c <= CH_LZ) return 7'(c - CH_LA) + 7'd10;
		if (c >= CH_UA && c <= CH_UZ) return 7'(c - CH_UA) + 7'd10;
		return NO_DIGIT;
	endfunction

	function automatic bit consume();
		if (used_count >= COUNT_W'(MAX_STRING_LEN)) begin
			scan_phase = SCAN_DONE;
			return 1'b0;
		end
		used_count++;
		return 1'b1;
	endfunction

	function automatic void accumulate(logic [7:0] c);
		logic [6:0] d;
		d = digit_value(c);
		if (c == CH_NUL || d == NO_DIGIT || d >= {1'b0, run_base}) begin
			scan_phase = SCAN_DONE;
			return;
		end
		if (!consume()) return;
		acc_value = acc_value * {58'd0, run_base} + {57'd0, d};
		scan_phase = SCAN_DIGITS;
	endfunction

	function automatic void open_number(logic [7:0] c);
		if (run_base == BASE_AUTO) begin
			if (c == CH_ZERO) begin
				run_base = BASE_OCT;
				if (consume()) scan_phase = SCAN_ZERO;
			end else begin
				run_base = BASE_DEC;
				accumulate(c);
			end
		end else if (run_base == BASE_HEX && c == CH_ZERO) begin
			if (consume()) scan_phase = SCAN_ZERO;
		end else begin
			accumulate(c);
		end
	endfunction

	function automatic parse_result_t parse_char(logic [7:0] c, logic opens);
		parse_result_t r;
		if (opens) begin
			scan_phase = SCAN_BLANK;
			neg_sign   = 1'b0;
			acc_value  = '0;
			used_count = '0;
		end
		case (scan_phase)
			SCAN_BLANK: begin
				run_base = base_reg;
				if (c == CH_SPACE || c == CH_TAB) begin
					void'(consume());
				end else if (c == CH_MINUS || c == CH_PLUS) begin
					if (consume()) begin
						neg_sign   = (c == CH_MINUS);
						scan_phase = SCAN_PREFIX;
					end
				end else begin
					open_number(c);
				end
			end
			SCAN_PREFIX: open_number(c);
			SCAN_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					run_base = BASE_HEX;
					if (consume()) scan_phase = SCAN_DIGITS;
				end else begin
					accumulate(c);
				end
			end
			SCAN_DIGITS: accumulate(c);
			default: scan_phase = SCAN_DONE;
		endcase
		r.value   = neg_sign ? -acc_value : acc_value;
		r.stopped = (scan_phase == SCAN_DONE);
		r.offset  = used_count;
		return r;
	endfunction

	function automatic int pick_gap(bit no_gaps);
		int unsigned r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 97) return $urandom_range(3, 8);
		return $urandom_range(12, 30);
	endfunction

	function automatic logic [7:0] digit_char(int unsigned d);
		if (d < 10) return CH_ZERO + 8'(d);
		return (($urandom_range(0, 1) == 0) ? CH_LA : CH_UA) + 8'(d - 10);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic opens,
			input bit fixed = 1'b0, input parse_result_t fixed_res = '0);
		int            gap;
		parse_result_t r;
		gap = pick_gap(quiet);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= c;
		s_axis_tuser  <= opens;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		r = parse_char(c, opens);
		expected_results.push_back(fixed ? fixed_res : r);
		char_count++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [BASE_W-1:0] b);
		drain();
		cfg_wdata <= b;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		base_reg = b;
	endtask

	task automatic send_number();
		int unsigned blanks, ndig, eff, top, d, r;
		logic        opens;
		opens  = 1'b1;
		blanks = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 3);
		repeat (blanks) begin
			send_char(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB, opens);
			opens = 1'b0;
		end
		r = $urandom_range(0, 2);
		if (r != 0) begin
			send_char((r == 1) ? CH_PLUS : CH_MINUS, opens);
			opens = 1'b0;
		end
		eff = base_reg;
		if (base_reg == BASE_AUTO || base_reg == BASE_HEX) begin
			r = $urandom_range(0, 2);
			if (r == 0) begin
				send_char(CH_ZERO, opens);
				opens = 1'b0;
				send_char(($urandom_range(0, 1) == 0) ? CH_LX : CH_UX, opens);
				eff = 16;
			end else if (r == 1 && base_reg == BASE_AUTO) begin
				send_char(CH_ZERO, opens);
				opens = 1'b0;
				eff = 8;
			end else if (base_reg == BASE_AUTO) begin
				eff = 10;
			end
		end
		top = (eff > 36) ? 36 : eff;
		r = $urandom_range(0, 99);
		ndig = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 12) : $urandom_range(13, 25);
		for (int i = 0; i < ndig; i++) begin
			d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 35) : $urandom_range(0, top - 1);
			if (i == 0 && base_reg == BASE_AUTO && eff == 10 && d == 0) d = 1;
			send_char(digit_char(d), opens);
			opens = 1'b0;
		end
		r = $urandom_range(0, 9);
		if (r >= 6) begin
			repeat ($urandom_range(1, 3)) begin
				send_char(8'($urandom_range(0, 255)), opens);
				opens = 1'b0;
			end
		end
		if (r != 9) send_char(CH_NUL, opens);
	endtask

	always @(posedge clk) begin : check_result
		parse_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[63:0] !== want.value) begin
					$display("%0t: parsed_value expected %h actual %h",
						$time, want.value, m_axis_tdata[63:0]);
					error_count++;
				end
				if (m_axis_tdata[64] !== want.stopped) begin
					$display("%0t: parse_stopped expected %b actual %b",
						$time, want.stopped, m_axis_tdata[64]);
					error_count++;
				end
				if (m_axis_tdata[76:65] !== want.offset) begin
					$display("%0t: end_offset expected %0d actual %0d",
						$time, want.offset, m_axis_tdata[76:65]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : result_ready
		int unsigned r;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			m_axis_tready <= 1'b1;
			repeat ((r < 10) ? 200 : $urandom_range(1, 20)) @(posedge clk);
			m_axis_tready <= 1'b0;
			repeat (pick_gap(1'b0) + 1) @(posedge clk);
		end
	end

	initial begin : stimulus
		string         wide_num;
		int            phase_start;
		parse_result_t tail_res;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tvalid = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_BASE)
				write_base(stim_table[i].code[BASE_W-1:0]);
			else
				send_char(stim_table[i].code, stim_table[i].opens, stim_table[i].fixed,
					stim_table[i].res);
		end

		for (int p = 0; p < 10; p++) begin
			write_base((p < 9) ? PHASE_BASES[p] : BASE_W'($urandom_range(0, 63)));
			quiet = (p % 4 == 3);
			phase_start = char_count;
			while (char_count - phase_start < 65) begin
				if ($urandom_range(0, 99) < 85)
					send_number();
				else
					send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end
		end

		// 2**63 wraps to the most negative value
		write_base(BASE_DEC);
		quiet = 1'b1;
		wide_num = "9223372036854775808";
		tail_res = '{64'h8000_0000_0000_0000, 1'b0, 12'd19};
		for (int i = 0; i < wide_num.len(); i++)
			send_char(wide_num[i], i == 0, i == wide_num.len() - 1, tail_res);
		send_char(CH_NUL, 1'b0);

		// run the consumed count into the string length bound
		send_char(CH_SPACE, 1'b1);
		repeat (4092) send_char(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB, 1'b0);
		send_char(CH_MINUS, 1'b0);
		send_char("7", 1'b0);
		tail_res = '{-64'sd7, 1'b1, 12'd4095};
		send_char("3", 1'b0, 1'b1, tail_res);
		send_char("1", 1'b0, 1'b1, tail_res);
		quiet = 1'b0;

		drain();
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
